// ----- design/ufrs_pkg.sv -----
// ----------------------------------------------------------------------------
// ufrs_pkg: shared types and constants for the UDP flow receive statistics
// Holds the flow table size, operation and status codes, the command that
// travels from the front end to the back end, and the flow entry layout.
// ----------------------------------------------------------------------------
package ufrs_pkg;

    // Number of flow slots in the table.
    localparam int FLOW_SLOTS = 64;
    localparam int SLOT_W     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;

    // Bandwidth scale and divider sizes.
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam int          DVD_W        = 68;
    localparam int          DIV_CNT_W    = $clog2(DVD_W + 1);

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_REPORT = 2'd1,
        OP_OPEN   = 2'd2,
        OP_CLOSE  = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_IGNORED       = 2'd1,
        ST_ZERO_INTERVAL = 2'd2
    } status_t;

    // Work for the back end, decided by the front end.
    typedef enum logic [2:0] {
        CMD_PACKET,
        CMD_REPORT,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_IGNORED
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       sequence_number;
        logic [15:0]       packet_length;
        logic [31:0]       transit_us;
        logic [31:0]       interval_us;
    } cmd_t;

    // One flow table entry.
    typedef struct packed {
        logic [31:0] highest_sequence;
        logic [31:0] last_transit;
        logic [47:0] byte_total;
        logic [31:0] packet_total;
        logic [31:0] out_of_order_total;
        logic [32:0] jitter_estimate;
    } entry_t;

    // Back end state machine.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_MUL,
        BK_DIV_START,
        BK_DIV_WAIT,
        BK_EMIT
    } bk_state_t;

endpackage

// ----- design/udp_flow_receive_stats_top.sv -----
// ----------------------------------------------------------------------------
// udp_flow_receive_stats_top: per-flow UDP receive statistics
// Front end classifies items against the open flags, a two-entry queue
// carries commands, and the back end updates the flow table and reports.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata (low bit up)                          tuser
//  s_       in   flow_slot, sequence_number, packet_length,  operation
//                transit_us, interval_us
//  m_       out  bytes_received, packets_total,              status
//                packets_out_of_order, jitter_us, bandwidth_bps
//
// In the back end, packet, open, close and ignored items go through the flow
// table read and then the update and result. A report with a nonzero interval
// also passes the bandwidth multiply and the 68-step bit-serial bandwidth
// divider. Reset clears the open flags and queue; the flow table needs no
// clearing pass. A stalled result holds the back end while the queue still
// takes up to two more items.
// ----------------------------------------------------------------------------
module udp_flow_receive_stats_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,  // flow_slot, sequence_number, packet_length,
                                   // transit_us, interval_us
    input  logic [7:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,  // bytes_received, packets_total,
                                   // packets_out_of_order, jitter_us, bandwidth_bps
    output logic [7:0]   m_tuser   // status
);
    import ufrs_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    ufrs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    ufrs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (head_cmd)
    );

    ufrs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- design/ufrs_front.sv -----
// ----------------------------------------------------------------------------
// ufrs_front: input acceptance and classification
// Keeps the per-slot open flags and turns each accepted item into a command
// for the back end.
// ----------------------------------------------------------------------------
module ufrs_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [119:0]  s_tdata,  // flow_slot, sequence_number, packet_length,
                                    // transit_us, interval_us (low bit up)
    input  logic [7:0]    s_tuser,  // operation
    input  logic          q_full,
    output logic          q_push,
    output ufrs_pkg::cmd_t q_cmd
);
    import ufrs_pkg::*;

    logic [FLOW_SLOTS-1:0] valid_reg;
    logic [FLOW_SLOTS-1:0] valid_next;
    logic [5:0]            slot_in;
    logic [SLOT_W+5:0]     slot_ext;
    logic [SLOT_W-1:0]     idx;
    logic                  in_range;
    logic                  is_open;
    op_t                   op;

    assign slot_in  = s_tdata[5:0];
    assign slot_ext = {{SLOT_W{1'b0}}, slot_in};
    assign idx      = slot_ext[SLOT_W-1:0];
    assign in_range = (13'(slot_in) < 13'(FLOW_SLOTS));
    assign is_open  = in_range && valid_reg[idx];
    assign op       = op_t'(s_tuser[1:0]);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Classify the item and update the open flags.
    always_comb begin
        valid_next                  = valid_reg;
        q_cmd.slot                  = idx;
        q_cmd.sequence_number       = s_tdata[37:6];
        q_cmd.packet_length         = s_tdata[53:38];
        q_cmd.transit_us            = s_tdata[85:54];
        q_cmd.interval_us           = s_tdata[117:86];
        q_cmd.kind                  = CMD_IGNORED;
        if (in_range) begin
            case (op)
                OP_OPEN: begin
                    q_cmd.kind = CMD_OPEN;
                    if (q_push) valid_next[idx] = 1'b1;
                end
                OP_CLOSE: begin
                    if (is_open) begin
                        q_cmd.kind = CMD_CLOSE;
                        if (q_push) valid_next[idx] = 1'b0;
                    end
                end
                OP_PACKET: if (is_open) q_cmd.kind = CMD_PACKET;
                OP_REPORT: if (is_open) q_cmd.kind = CMD_REPORT;
                default:   q_cmd.kind = CMD_IGNORED;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= '0;
        else          valid_reg <= valid_next;
    end

endmodule

// ----- design/ufrs_queue.sv -----
// ----------------------------------------------------------------------------
// ufrs_queue: two-entry command queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ufrs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ufrs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output ufrs_pkg::cmd_t head
);
    import ufrs_pkg::*;

    cmd_t       store_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = store_reg[rd_ptr_reg];

    // Pointer and count update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) store_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- design/ufrs_div.sv -----
// ----------------------------------------------------------------------------
// ufrs_div: radix-2 restoring divider
// Divides a 68-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ufrs_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ufrs_pkg::DVD_W-1:0]  dividend,
    input  logic [31:0]                 divisor,
    output logic                        done,
    output logic [ufrs_pkg::DVD_W-1:0]  quotient
);
    import ufrs_pkg::*;

    logic [DVD_W-1:0]     quo_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [32:0]          trial;
    logic                 fits;

    // Shift in one dividend bit and try the subtraction.
    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign fits     = (trial >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
        end
    end

endmodule

// ----- design/ufrs_back.sv -----
// ----------------------------------------------------------------------------
// ufrs_back: flow table update and result generation
// Runs one command at a time against the flow table memory and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module ufrs_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  ufrs_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [199:0]   m_tdata,  // bytes_received, packets_total,
                                     // packets_out_of_order, jitter_us,
                                     // bandwidth_bps (low bit up)
    output logic [7:0]     m_tuser   // status
);
    import ufrs_pkg::*;

    localparam logic [47:0] MAX48 = '1;
    localparam logic [31:0] MAX32 = '1;

    // Flow table memory with registered read.
    entry_t           mem [FLOW_SLOTS];
    entry_t           rd_reg;
    logic             mem_we;
    entry_t           wr_entry;

    bk_state_t        state_reg, state_next;
    cmd_t             cmd_reg;

    // Result staging for reports.
    entry_t           rep_reg;
    logic [51:0]      prod_lo_reg;
    logic [35:0]      prod_hi_reg;
    logic [47:0]      bw_reg;
    status_t          rep_status_reg;

    // Output register.
    logic             m_valid_reg, m_valid_next;
    status_t          m_status_reg;
    logic [47:0]      m_bytes_reg;
    logic [31:0]      m_pkts_reg;
    logic [31:0]      m_ooo_reg;
    logic [32:0]      m_jit_reg;
    logic [47:0]      m_bw_reg;

    logic             out_free;
    logic             emit_simple;
    logic             emit_report;
    logic             save_report;
    logic             div_start;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DVD_W-1:0] dividend;

    // Packet arithmetic.
    logic [32:0]      dt;
    logic [32:0]      dt_abs;
    logic [33:0]      jd;
    logic [33:0]      jd_mag;
    logic [33:0]      jd_step;
    logic [33:0]      jit_sum;
    logic [48:0]      byte_sum;
    logic             in_order;

    function automatic logic [32:0] q_to_s33(input logic [31:0] v);
        return {v[31], v};
    endfunction

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {6'd0, m_status_reg};
    assign m_tdata  = {7'd0, m_bw_reg, m_jit_reg, m_ooo_reg, m_pkts_reg, m_bytes_reg};

    // RFC 3550 jitter step, truncating toward zero, and counter updates.
    always_comb begin
        dt       = 33'($signed(q_to_s33(cmd_reg.transit_us))
                     - $signed(q_to_s33(rd_reg.last_transit)));
        dt_abs   = dt[32] ? 33'(-dt) : dt;
        jd       = {1'b0, dt_abs} - {1'b0, rd_reg.jitter_estimate};
        jd_mag   = jd[33] ? 34'(-jd) : jd;
        jd_step  = jd[33] ? 34'(-(jd_mag >> 4)) : (jd_mag >> 4);
        jit_sum  = {1'b0, rd_reg.jitter_estimate} + jd_step;
        byte_sum = {1'b0, rd_reg.byte_total} + 49'(cmd_reg.packet_length);
        in_order = ({1'b0, cmd_reg.sequence_number}
                    >= ({1'b0, rd_reg.highest_sequence} + 33'd1));
    end

    // Next entry value and sequencing.
    always_comb begin
        state_next  = state_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        wr_entry    = rd_reg;
        emit_simple = 1'b0;
        emit_report = 1'b0;
        save_report = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                case (cmd_reg.kind)
                    CMD_PACKET: begin
                        wr_entry.byte_total = byte_sum[48] ? MAX48 : byte_sum[47:0];
                        if (rd_reg.packet_total != MAX32)
                            wr_entry.packet_total = rd_reg.packet_total + 32'd1;
                        if (in_order)
                            wr_entry.highest_sequence = cmd_reg.sequence_number;
                        else if (rd_reg.out_of_order_total != MAX32)
                            wr_entry.out_of_order_total = rd_reg.out_of_order_total + 32'd1;
                        wr_entry.jitter_estimate = jit_sum[32:0];
                        wr_entry.last_transit    = cmd_reg.transit_us;
                        if (out_free) begin
                            mem_we      = 1'b1;
                            emit_simple = 1'b1;
                            state_next  = BK_IDLE;
                        end
                    end
                    CMD_REPORT: begin
                        wr_entry.byte_total         = '0;
                        wr_entry.packet_total       = '0;
                        wr_entry.out_of_order_total = '0;
                        wr_entry.jitter_estimate    = '0;
                        mem_we      = 1'b1;
                        save_report = 1'b1;
                        state_next  = (cmd_reg.interval_us == '0) ? BK_EMIT : BK_MUL;
                    end
                    CMD_OPEN: begin
                        wr_entry = '0;
                        if (out_free) begin
                            mem_we      = 1'b1;
                            emit_simple = 1'b1;
                            state_next  = BK_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit_simple = 1'b1;
                            state_next  = BK_IDLE;
                        end
                    end
                endcase
            end
            BK_MUL:       state_next = BK_DIV_START;
            BK_DIV_START: begin
                div_start  = 1'b1;
                state_next = BK_DIV_WAIT;
            end
            BK_DIV_WAIT:  if (div_done) state_next = BK_EMIT;
            BK_EMIT: begin
                if (out_free) begin
                    emit_report = 1'b1;
                    state_next  = BK_IDLE;
                end
            end
            default:      state_next = BK_IDLE;
        endcase
    end

    // Output register handshake.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) m_valid_next = 1'b0;
        if (emit_simple || emit_report) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Flow table access.
    always_ff @(posedge aclk) begin
        if (mem_we) mem[cmd_reg.slot] <= wr_entry;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_reg  <= mem[q_head.slot];
            cmd_reg <= q_head;
        end
    end

    // Report staging: split product of bytes and the microsecond scale.
    assign dividend = {prod_hi_reg, 32'd0} + 68'(prod_lo_reg);

    always_ff @(posedge aclk) begin
        if (save_report) begin
            rep_reg        <= rd_reg;
            bw_reg         <= MAX48;
            rep_status_reg <= (cmd_reg.interval_us == '0) ? ST_ZERO_INTERVAL : ST_OK;
        end
        if (state_reg == BK_MUL) begin
            prod_lo_reg <= rep_reg.byte_total[31:0] * USEC_PER_SEC;
            prod_hi_reg <= rep_reg.byte_total[47:32] * USEC_PER_SEC;
        end
        if (div_done)
            bw_reg <= (div_quo[DVD_W-1:48] != '0) ? MAX48 : div_quo[47:0];
    end

    ufrs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (cmd_reg.interval_us),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Output payload.
    always_ff @(posedge aclk) begin
        if (emit_simple) begin
            m_status_reg <= (cmd_reg.kind == CMD_IGNORED) ? ST_IGNORED : ST_OK;
            m_bytes_reg  <= '0;
            m_pkts_reg   <= '0;
            m_ooo_reg    <= '0;
            m_jit_reg    <= '0;
            m_bw_reg     <= '0;
        end else if (emit_report) begin
            m_status_reg <= rep_status_reg;
            m_bytes_reg  <= rep_reg.byte_total;
            m_pkts_reg   <= rep_reg.packet_total;
            m_ooo_reg    <= rep_reg.out_of_order_total;
            m_jit_reg    <= rep_reg.jitter_estimate;
            m_bw_reg     <= bw_reg;
        end
    end

endmodule

// ----- tb/udp_flow_receive_stats_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// udp_flow_receive_stats_top_tb: self-checking bench for the flow statistics
// Drives packet, report, open and close items into the input stream. A
// behavioral flow table predicts each result, and a monitor compares every
// result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module udp_flow_receive_stats_top_tb;
    import ufrs_pkg::*;

    // Field layout of one input item and one result item.
    typedef struct {
        op_t         op;
        logic [5:0]  slot;
        logic [31:0] seq;
        logic [15:0] len;
        logic [31:0] transit;
        logic [31:0] interval;
    } flow_item_t;

    typedef struct {
        status_t     status;
        logic [47:0] bytes;
        logic [31:0] packets;
        logic [31:0] misordered;
        logic [32:0] jitter;
        logic [47:0] bandwidth;
    } flow_result_t;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [7:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic [7:0]   m_tuser;

    udp_flow_receive_stats_top uut (.*);

    // Predicted flow table.
    logic        tbl_open [64];
    logic [31:0] tbl_high [64];
    logic [31:0] tbl_last [64];
    logic [47:0] tbl_bytes [64];
    logic [31:0] tbl_pkts [64];
    logic [31:0] tbl_ooo [64];
    logic [32:0] tbl_jit [64];

    flow_item_t   pending_items[$];
    flow_result_t expected_results[$];
    int           error_count = 0;
    bit           quiet_send = 0;   // no random gaps on the input
    bit           quiet_recv = 0;   // no random stalls on the output
    bit           recv_hold = 0;    // long output stall in progress
    int           hold_cycles = 0;

    // Bandwidth: 1e6 * bytes / interval, saturated to 48 bits.
    function automatic logic [47:0] bandwidth_of(logic [47:0] bytes, logic [31:0] iv);
        logic [67:0] q;
        q = ({20'd0, bytes} * 68'd1000000) / {36'd0, iv};
        return (q > {20'd0, MAX48}) ? MAX48 : q[47:0];
    endfunction

    // Apply one item to the predicted table and return its result.
    function automatic flow_result_t predict_stats(flow_item_t it);
        flow_result_t r;
        longint signed delta, j;
        logic [48:0] bsum;
        int s;
        r = '{ST_OK, 0, 0, 0, 0, 0};
        s = int'(it.slot);
        if (it.op == OP_OPEN) begin
            tbl_open[s] = 1; tbl_high[s] = 0; tbl_last[s] = 0; tbl_bytes[s] = 0;
            tbl_pkts[s] = 0; tbl_ooo[s] = 0; tbl_jit[s] = 0;
            return r;
        end
        if (!tbl_open[s]) begin
            r.status = ST_IGNORED;
            return r;
        end
        case (it.op)
            OP_CLOSE: begin
                tbl_open[s] = 0;
            end
            OP_PACKET: begin
                bsum = tbl_bytes[s] + it.len;
                tbl_bytes[s] = bsum[48] ? MAX48 : bsum[47:0];
                if (tbl_pkts[s] != '1) tbl_pkts[s]++;
                if ({1'b0, it.seq} >= {1'b0, tbl_high[s]} + 33'd1) tbl_high[s] = it.seq;
                else if (tbl_ooo[s] != '1) tbl_ooo[s]++;
                delta = longint'($signed(it.transit)) - longint'($signed(tbl_last[s]));
                if (delta < 0) delta = -delta;
                j = longint'(tbl_jit[s]);
                j = j + (delta - j) / 16;
                tbl_jit[s] = j[32:0];
                tbl_last[s] = it.transit;
            end
            default: begin
                r.bytes = tbl_bytes[s];
                r.packets = tbl_pkts[s];
                r.misordered = tbl_ooo[s];
                r.jitter = tbl_jit[s];
                if (it.interval == 0) begin
                    r.status = ST_ZERO_INTERVAL;
                    r.bandwidth = MAX48;
                end else begin
                    r.bandwidth = bandwidth_of(tbl_bytes[s], it.interval);
                end
                tbl_bytes[s] = 0; tbl_pkts[s] = 0; tbl_ooo[s] = 0; tbl_jit[s] = 0;
            end
        endcase
        return r;
    endfunction

    function automatic flow_item_t make_item(op_t op, int slot, logic [31:0] seq,
                                             logic [15:0] len, logic [31:0] tr,
                                             logic [31:0] iv);
        flow_item_t it;
        it.op = op; it.slot = 6'(slot); it.seq = seq; it.len = len;
        it.transit = tr; it.interval = iv;
        return it;
    endfunction

    // Clock.
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Sender: offers queued items, with random gaps.
    always @(posedge aclk) begin
        flow_item_t it;
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() > 0 && (quiet_send || $urandom_range(99) >= 29)) begin
                it = pending_items.pop_front();
                expected_results.push_back(predict_stats(it));
                s_tvalid <= 1;
                s_tdata  <= {2'd0, it.interval, it.transit, it.len, it.seq, it.slot};
                s_tuser  <= {6'd0, it.op};
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // Receiver ready: random stalls, plus a long hold counted here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            hold_cycles <= 0;
        end else if (recv_hold && hold_cycles < 300) begin
            m_tready <= 0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            m_tready <= quiet_recv || ($urandom_range(99) >= 29);
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge aclk) begin
        flow_result_t exp_r, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = status_t'(m_tuser[1:0]);
            got.bytes      = m_tdata[47:0];
            got.packets    = m_tdata[79:48];
            got.misordered = m_tdata[111:80];
            got.jitter     = m_tdata[144:112];
            got.bandwidth  = m_tdata[192:145];
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: tdata=%h tuser=%h",
                         $realtime, m_tdata, m_tuser);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             exp_r.status, got.status);
                    error_count++;
                end
                if (got.bytes !== exp_r.bytes) begin
                    $display("%0t: bytes expected %0d actual %0d", $realtime,
                             exp_r.bytes, got.bytes);
                    error_count++;
                end
                if (got.packets !== exp_r.packets) begin
                    $display("%0t: packets expected %0d actual %0d", $realtime,
                             exp_r.packets, got.packets);
                    error_count++;
                end
                if (got.misordered !== exp_r.misordered) begin
                    $display("%0t: out of order expected %0d actual %0d", $realtime,
                             exp_r.misordered, got.misordered);
                    error_count++;
                end
                if (got.jitter !== exp_r.jitter) begin
                    $display("%0t: jitter expected %0d actual %0d", $realtime,
                             exp_r.jitter, got.jitter);
                    error_count++;
                end
                if (got.bandwidth !== exp_r.bandwidth) begin
                    $display("%0t: bandwidth expected %0d actual %0d", $realtime,
                             exp_r.bandwidth, got.bandwidth);
                    error_count++;
                end
            end
        end
    end

    // Wait until the queue has drained and every prediction is matched.
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
    endtask

    // Random well-formed flow: open, packets with mostly rising sequence numbers,
    // reports along the way, sometimes a close.
    task automatic queue_flow(int slot);
        logic [31:0] seq, tr;
        int n;
        seq = $urandom_range(3) == 0 ? 32'hFFFF_FFF0 : $urandom_range(1000);
        tr = $urandom();
        pending_items.push_back(make_item(OP_OPEN, slot, 0, 0, 0, 0));
        n = $urandom_range(12, 2);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(4) == 0) seq = seq - $urandom_range(5);
            else seq = seq + $urandom_range(3, 1);
            tr = $urandom_range(1) ? tr + $urandom_range(2000) - 1000 : $urandom();
            pending_items.push_back(make_item(OP_PACKET, slot, seq, 16'($urandom()), tr, 0));
            if ($urandom_range(5) == 0)
                pending_items.push_back(make_item(OP_REPORT, slot, 0, 0, 0,
                    $urandom_range(3) == 0 ? $urandom_range(2) : $urandom()));
        end
        pending_items.push_back(make_item(OP_REPORT, slot, $urandom(), 16'($urandom()),
                                          $urandom(), $urandom_range(1) ? $urandom() :
                                          $urandom_range(1000)));
        if ($urandom_range(2) == 0)
            pending_items.push_back(make_item(OP_CLOSE, slot, 0, 0, 0, 0));
    endtask

    // Stimulus.
    initial begin
        for (int i = 0; i < 64; i++) tbl_open[i] = 0;
        aresetn = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // Directed: closed-slot cases, extremes, saturation and wrap corners.
        pending_items.push_back(make_item(OP_PACKET, 63, '1, '1, '1, '1));
        pending_items.push_back(make_item(OP_REPORT, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_CLOSE, 5, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_OPEN, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_PACKET, 0, 0, 16'hFFFF, 32'h8000_0000, 0));
        pending_items.push_back(make_item(OP_PACKET, 0, '1, 16'hFFFF, 32'h7FFF_FFFF, 0));
        pending_items.push_back(make_item(OP_PACKET, 0, '1, 0, 32'h8000_0000, 0));
        pending_items.push_back(make_item(OP_PACKET, 0, 0, 1, 0, 0));
        pending_items.push_back(make_item(OP_REPORT, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_PACKET, 0, 7, 16'hFFFF, 5, 0));
        pending_items.push_back(make_item(OP_REPORT, 0, 0, 0, 0, 1));
        pending_items.push_back(make_item(OP_PACKET, 0, 7, 100, 5, 0));
        pending_items.push_back(make_item(OP_REPORT, 0, 0, 0, 0, '1));
        pending_items.push_back(make_item(OP_OPEN, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_REPORT, 0, 0, 0, 0, 3));
        pending_items.push_back(make_item(OP_CLOSE, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_PACKET, 0, 1, 1, 1, 0));
        pending_items.push_back(make_item(OP_OPEN, 63, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_PACKET, 63, 1, 40, -32'sd20, 0));
        pending_items.push_back(make_item(OP_REPORT, 63, 0, 0, 0, 7));
        pending_items.push_back(make_item(OP_CLOSE, 63, 0, 0, 0, 0));
        wait_drained();

        // Random, first with no idling on either side.
        quiet_send = 1; quiet_recv = 1;
        for (int f = 0; f < 8; f++) queue_flow($urandom_range(63));
        wait_drained();
        quiet_send = 0; quiet_recv = 0;

        // Long output stall while the sender keeps offering items.
        for (int f = 0; f < 4; f++) queue_flow($urandom_range(63));
        recv_hold = 1;
        wait_drained();
        recv_hold = 0;

        // Mixed well-formed flows and noise on any slot.
        for (int f = 0; f < 45; f++) begin
            queue_flow($urandom_range(63));
            if ($urandom_range(2) == 0)
                pending_items.push_back(make_item(op_t'($urandom_range(3)),
                    $urandom_range(63), $urandom(), 16'($urandom()), $urandom(),
                    $urandom()));
        end
        wait_drained();
        repeat (200) @(posedge aclk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Timeout.
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
